// ===== rtl/alcx_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alcx_pkg
// Shared types, constants and the x^1.4 power table of the lux calculator.
// ----------------------------------------------------------------------------
package alcx_pkg;

    localparam int POW_TABLE_ENTRIES = 256;
    localparam int LUX_FRACTION_BITS = 8;

    localparam int CNT_W    = 16;
    localparam int LUX_W    = 19;
    localparam int RGN_W    = 3;
    localparam int TAB_M    = POW_TABLE_ENTRIES - 1;
    localparam int IDX_W    = $clog2(POW_TABLE_ENTRIES);
    localparam int QUO_W    = IDX_W + 1;
    localparam int NUM_W    = CNT_W + $clog2(4 * TAB_M + 2);
    localparam int DEN_W    = CNT_W + 1;
    localparam int POW_W    = 16;
    localparam int COEF_W   = 28;
    localparam int PROD_W   = CNT_W + POW_W;
    localparam int POS_W    = COEF_W + CNT_W;
    localparam int CMP_W    = CNT_W + 8;
    localparam int LUX_SH   = 32 - LUX_FRACTION_BITS;

    localparam int DIV_STAGES = 3;
    localparam int DIV_SPS    = (QUO_W + DIV_STAGES - 1) / DIV_STAGES;

    // table ratio step 32768/M split into whole and leftover parts
    localparam longint unsigned TAB_STEP_Q = 32768 / TAB_M;
    localparam longint unsigned TAB_STEP_R = 32768 % TAB_M;

    localparam logic [LUX_W-1:0] LUX_MAX = {LUX_W{1'b1}};

    // region limits as percent of broadband
    localparam logic [7:0] PCT_SCALE = 8'd100;
    localparam logic [7:0] PCT_R0    = 8'd50;
    localparam logic [7:0] PCT_R1    = 8'd61;
    localparam logic [7:0] PCT_R2    = 8'd80;
    localparam logic [7:0] PCT_R3    = 8'd130;

    typedef enum logic [RGN_W-1:0] {
        RGN_0   = 3'd0,
        RGN_1   = 3'd1,
        RGN_2   = 3'd2,
        RGN_3   = 3'd3,
        RGN_OFF = 3'd4
    } region_t;

    // Q32 coefficients, rounded to nearest
    localparam logic [COEF_W-1:0] C_R0_A = COEF_W'(((64'd304 << 32) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] C_R0_B = COEF_W'(((64'd62 << 32) + 64'd500) / 64'd1000);
    localparam logic [COEF_W-1:0] C_R1_A = COEF_W'(((64'd224 << 32) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] C_R1_B = COEF_W'(((64'd31 << 32) + 64'd500) / 64'd1000);
    localparam logic [COEF_W-1:0] C_R2_A = COEF_W'(((64'd128 << 32) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] C_R2_B = COEF_W'(((64'd153 << 32) + 64'd5000) / 64'd10000);
    localparam logic [COEF_W-1:0] C_R3_A = COEF_W'(((64'd146 << 32) + 64'd50000) / 64'd100000);
    localparam logic [COEF_W-1:0] C_R3_B = COEF_W'(((64'd112 << 32) + 64'd50000) / 64'd100000);

    typedef logic [POW_W-1:0] pow_tab_t [POW_TABLE_ENTRIES];

    function automatic longint unsigned fifth_q16(longint unsigned y);
        longint unsigned p;
        p = (y * y) >> 16;
        p = (p * y) >> 16;
        p = (p * y) >> 16;
        p = (p * y) >> 16;
        return p;
    endfunction

    // entry i: x^1.4 in Q16 for x = i/(2M), root found by bisection
    function automatic pow_tab_t build_pow_tab();
        pow_tab_t        tab;
        longint unsigned x;
        longint unsigned xr;
        longint unsigned t;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        x  = 0;
        xr = 0;
        for (int i = 0; i < POW_TABLE_ENTRIES; i++) begin
            // x = floor(i*32768/M), stepped without a divide
            if (i > 0) begin
                x  = x + TAB_STEP_Q;
                xr = xr + TAB_STEP_R;
                if (xr >= longint'(TAB_M)) begin
                    xr = xr - longint'(TAB_M);
                    x  = x + 1;
                end
            end
            t  = (x * x) >> 16;
            lo = 0;
            hi = 65535;
            for (int j = 0; j < 17; j++) begin
                if (lo < hi) begin
                    mid = (lo + hi + 1) >> 1;
                    if (fifth_q16(mid) <= t)
                        lo = mid;
                    else
                        hi = mid - 1;
                end
            end
            tab[i] = POW_W'((x * lo) >> 16);
        end
        return tab;
    endfunction

    localparam pow_tab_t POW_TAB = build_pow_tab();

    typedef struct packed {
        logic [CNT_W-1:0] broadband_count;
        logic [CNT_W-1:0] infrared_count;
    } sample_t;

    typedef struct packed {
        logic [LUX_W-1:0] lux;
        logic [RGN_W-1:0] ratio_region;
    } result_t;

    // item as it travels through the divider
    typedef struct packed {
        logic [CNT_W-1:0] ch0;
        logic [CNT_W-1:0] ch1;
        region_t          region;
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } div_t;

endpackage
`default_nettype wire

// ===== rtl/alcx_prep.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alcx_prep
// Region select and divider operand setup (one register stage).
// ----------------------------------------------------------------------------
module alcx_prep (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            advance,
    input  wire logic            in_valid,
    input  wire alcx_pkg::sample_t in_item,
    output logic                 out_valid,
    output alcx_pkg::div_t       out_item
);

    logic                  valid_reg;
    alcx_pkg::div_t        item_reg;
    alcx_pkg::div_t        item_next;
    logic [alcx_pkg::CMP_W-1:0] p_ch1;
    logic [alcx_pkg::CMP_W-1:0] lim0;
    logic [alcx_pkg::CMP_W-1:0] lim1;
    logic [alcx_pkg::CMP_W-1:0] lim2;
    logic [alcx_pkg::CMP_W-1:0] lim3;

    always_comb
    begin
        p_ch1 = alcx_pkg::CMP_W'(in_item.infrared_count) * alcx_pkg::CMP_W'(alcx_pkg::PCT_SCALE);
        lim0  = alcx_pkg::CMP_W'(in_item.broadband_count) * alcx_pkg::CMP_W'(alcx_pkg::PCT_R0);
        lim1  = alcx_pkg::CMP_W'(in_item.broadband_count) * alcx_pkg::CMP_W'(alcx_pkg::PCT_R1);
        lim2  = alcx_pkg::CMP_W'(in_item.broadband_count) * alcx_pkg::CMP_W'(alcx_pkg::PCT_R2);
        lim3  = alcx_pkg::CMP_W'(in_item.broadband_count) * alcx_pkg::CMP_W'(alcx_pkg::PCT_R3);

        item_next.ch0 = in_item.broadband_count;
        item_next.ch1 = in_item.infrared_count;
        if (in_item.broadband_count == '0 || p_ch1 > lim3)
            item_next.region = alcx_pkg::RGN_OFF;
        else if (p_ch1 <= lim0)
            item_next.region = alcx_pkg::RGN_0;
        else if (p_ch1 <= lim1)
            item_next.region = alcx_pkg::RGN_1;
        else if (p_ch1 <= lim2)
            item_next.region = alcx_pkg::RGN_2;
        else
            item_next.region = alcx_pkg::RGN_3;

        // rounded index: (4M*ch1 + ch0) / (2*ch0)
        item_next.rem = alcx_pkg::NUM_W'(in_item.infrared_count)
                        * alcx_pkg::NUM_W'(4 * alcx_pkg::TAB_M)
                        + alcx_pkg::NUM_W'(in_item.broadband_count);
        item_next.den = {in_item.broadband_count, 1'b0};
        item_next.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
`default_nettype wire

// ===== rtl/alcx_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alcx_divider
// Pipelined restoring divider for the power table index, a few quotient
// bits per stage.
// ----------------------------------------------------------------------------
module alcx_divider (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire logic           in_valid,
    input  wire alcx_pkg::div_t in_item,
    output logic                out_valid,
    output alcx_pkg::div_t      out_item
);

    localparam int WIDE_W = alcx_pkg::NUM_W + alcx_pkg::QUO_W;

    logic [alcx_pkg::DIV_STAGES-1:0] valid_reg;
    alcx_pkg::div_t                  item_reg  [alcx_pkg::DIV_STAGES];
    alcx_pkg::div_t                  item_next [alcx_pkg::DIV_STAGES];

    function automatic alcx_pkg::div_t div_steps(alcx_pkg::div_t d, int first);
        alcx_pkg::div_t    r;
        logic [WIDE_W-1:0] dk;
        int                k;
        r = d;
        for (int j = 0; j < alcx_pkg::DIV_SPS; j++) begin
            if (first + j < alcx_pkg::QUO_W) begin
                k  = alcx_pkg::QUO_W - 1 - (first + j);
                dk = WIDE_W'(r.den) << k;
                if (WIDE_W'(r.rem) >= dk) begin
                    r.rem = r.rem - dk[alcx_pkg::NUM_W-1:0];
                    r.quo = r.quo | (alcx_pkg::QUO_W'(1) << k);
                end
            end
        end
        return r;
    endfunction

    always_comb
    begin
        item_next[0] = div_steps(in_item, 0);
        for (int s = 1; s < alcx_pkg::DIV_STAGES; s++)
            item_next[s] = div_steps(item_reg[s-1], s * alcx_pkg::DIV_SPS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (advance)
            valid_reg <= {valid_reg[alcx_pkg::DIV_STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < alcx_pkg::DIV_STAGES; s++)
                item_reg[s] <= item_next[s];
        end
    end

    assign out_valid = valid_reg[alcx_pkg::DIV_STAGES-1];
    assign out_item  = item_reg[alcx_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/alcx_formula.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alcx_formula
// Lux formula: table lookup and products, region 0 power term, then
// difference, rounding and saturation (three register stages).
// ----------------------------------------------------------------------------
module alcx_formula (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire logic           in_valid,
    input  wire alcx_pkg::div_t in_item,
    output logic                out_valid,
    output alcx_pkg::result_t   out_item
);

    localparam int SUM_W = alcx_pkg::POS_W + 1;

    // stage a
    logic                         a_valid_reg;
    alcx_pkg::region_t            a_region_reg;
    logic [alcx_pkg::POS_W-1:0]   a_pos_reg;
    logic [alcx_pkg::POS_W-1:0]   a_negl_reg;
    logic [alcx_pkg::PROD_W-1:0]  a_prod_reg;
    logic [alcx_pkg::COEF_W-1:0]  coef_a;
    logic [alcx_pkg::COEF_W-1:0]  coef_b;
    logic [alcx_pkg::IDX_W-1:0]   idx;
    logic [alcx_pkg::POW_W-1:0]   pow_val;

    // stage b
    logic                         b_valid_reg;
    alcx_pkg::region_t            b_region_reg;
    logic [alcx_pkg::POS_W-1:0]   b_pos_reg;
    logic [alcx_pkg::POS_W-1:0]   b_neg_reg;
    logic [alcx_pkg::PROD_W+alcx_pkg::COEF_W-1:0] neg0_full;
    logic [alcx_pkg::POS_W-1:0]   neg_next;

    // stage c
    logic                         c_valid_reg;
    alcx_pkg::result_t            c_item_reg;
    logic [SUM_W-1:0]             diff;
    logic [SUM_W-1:0]             rounded;
    alcx_pkg::result_t            c_item_next;

    always_comb
    begin
        case (in_item.region)
            alcx_pkg::RGN_0:
            begin
                coef_a = alcx_pkg::C_R0_A;
                coef_b = '0;
            end
            alcx_pkg::RGN_1:
            begin
                coef_a = alcx_pkg::C_R1_A;
                coef_b = alcx_pkg::C_R1_B;
            end
            alcx_pkg::RGN_2:
            begin
                coef_a = alcx_pkg::C_R2_A;
                coef_b = alcx_pkg::C_R2_B;
            end
            alcx_pkg::RGN_3:
            begin
                coef_a = alcx_pkg::C_R3_A;
                coef_b = alcx_pkg::C_R3_B;
            end
            default:
            begin
                coef_a = '0;
                coef_b = '0;
            end
        endcase

        if (in_item.quo > alcx_pkg::QUO_W'(alcx_pkg::TAB_M))
            idx = alcx_pkg::IDX_W'(alcx_pkg::TAB_M);
        else
            idx = in_item.quo[alcx_pkg::IDX_W-1:0];
        pow_val = alcx_pkg::POW_TAB[idx];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_region_reg <= in_item.region;
            a_pos_reg    <= alcx_pkg::POS_W'(coef_a) * alcx_pkg::POS_W'(in_item.ch0);
            a_negl_reg   <= alcx_pkg::POS_W'(coef_b) * alcx_pkg::POS_W'(in_item.ch1);
            a_prod_reg   <= alcx_pkg::PROD_W'(in_item.ch0) * alcx_pkg::PROD_W'(pow_val);
        end
    end

    always_comb
    begin
        neg0_full = (alcx_pkg::PROD_W+alcx_pkg::COEF_W)'(a_prod_reg)
                    * (alcx_pkg::PROD_W+alcx_pkg::COEF_W)'(alcx_pkg::C_R0_B);
        if (a_region_reg == alcx_pkg::RGN_0)
            neg_next = neg0_full[alcx_pkg::PROD_W+alcx_pkg::COEF_W-1:16];
        else
            neg_next = a_negl_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            b_region_reg <= a_region_reg;
            b_pos_reg    <= a_pos_reg;
            b_neg_reg    <= neg_next;
        end
    end

    // clamp negative to zero, round half up, saturate
    always_comb
    begin
        diff    = SUM_W'(b_pos_reg) - SUM_W'(b_neg_reg);
        rounded = (diff + (SUM_W'(1) << (alcx_pkg::LUX_SH - 1))) >> alcx_pkg::LUX_SH;
        c_item_next.ratio_region = b_region_reg;
        if (b_region_reg == alcx_pkg::RGN_OFF || b_pos_reg <= b_neg_reg)
            c_item_next.lux = '0;
        else if (rounded > SUM_W'(alcx_pkg::LUX_MAX))
            c_item_next.lux = alcx_pkg::LUX_MAX;
        else
            c_item_next.lux = rounded[alcx_pkg::LUX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            c_item_reg <= c_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_item_reg;

endmodule
`default_nettype wire

// ===== rtl/ambient_light_lux_calc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ambient_light_lux_calc
// Lux from a broadband / infrared photodiode count pair.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel: sample_valid / sample_stall / sample (broadband_count,
//   infrared_count). An item is taken on a rising edge with valid high and
//   stall low.
//   result channel: result_valid / result_stall / result (lux in 1/256 lux,
//   ratio_region 0..4). One result item per sample item, in order.
//   Stages: 1 region/operand stage, 3 divider stages (index of the x^1.4
//   table), 3 formula stages (products, power term, round). Throughput is
//   one item per cycle when not stalled; the pipeline registers are the only
//   limit, each holding at most one multiply or a few 26-bit subtracts.
//   When the receiver stalls a valid result, the whole pipeline holds and
//   sample_stall rises in the same cycle; nothing is dropped or repeated.
//   Bubbles behind a stalled result are kept, not squeezed out.
//   Reset clears all valid bits; the power table is constant logic and
//   needs no fill, so items are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
module ambient_light_lux_calc (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              sample_valid,
    output logic                   sample_stall,
    input  wire alcx_pkg::sample_t sample,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output alcx_pkg::result_t      result
);

    logic           advance;
    logic           prep_valid;
    alcx_pkg::div_t prep_item;
    logic           div_valid;
    alcx_pkg::div_t div_item;

    // a held result freezes every stage
    assign advance      = !(result_valid && result_stall);
    assign sample_stall = !advance;

    alcx_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (sample_valid),
        .in_item   (sample),
        .out_valid (prep_valid),
        .out_item  (prep_item)
    );

    alcx_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (prep_valid),
        .in_item   (prep_item),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    alcx_formula u_formula (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (div_valid),
        .in_item   (div_item),
        .out_valid (result_valid),
        .out_item  (result)
    );

    // off region always reads zero lux
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.ratio_region == alcx_pkg::RGN_OFF |-> result.lux == '0)
    else $error("nonzero lux in off region");

    // region code stays in range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.ratio_region <= alcx_pkg::RGN_OFF)
    else $error("region code out of range");

    // input is held back only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid && result_stall)
    else $error("input stalled without output stall");

endmodule
`default_nettype wire
